// File: design/apt_pkg.sv
// ============================================================================
// apt_pkg: shared types and constants for the affine point transform
// Fixed-point formats, register indexes and reset values of the matrix.
// ============================================================================
package apt_pkg;

    localparam int NUM_AXES   = 3;
    localparam int COORD_W    = 32;
    localparam int COEF_W     = 16;
    localparam int ROW_W      = NUM_AXES * COEF_W;
    localparam int PROD_W     = COORD_W + COEF_W;
    localparam int COEF_FRAC  = 14;
    localparam int RND_W      = PROD_W - COEF_FRAC;
    localparam int SUM_W      = RND_W + 2;
    localparam int CFG_IDX_W  = 3;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [COEF_W-1:0]  coef_t;
    typedef logic        [ROW_W-1:0]   row_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [RND_W-1:0]   rnd_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic        [CFG_IDX_W-1:0] cfg_idx_t;

    // Register indexes of the configuration port
    localparam cfg_idx_t REG_ROW_X   = 3'd0;
    localparam cfg_idx_t REG_ROW_Y   = 3'd1;
    localparam cfg_idx_t REG_ROW_Z   = 3'd2;
    localparam cfg_idx_t REG_SHIFT_X = 3'd3;
    localparam cfg_idx_t REG_SHIFT_Y = 3'd4;
    localparam cfg_idx_t REG_SHIFT_Z = 3'd5;

    // Identity matrix: 1.0 in Q2.14 on the diagonal
    localparam row_t ROW_X_RESET = 48'h0000_0000_4000;
    localparam row_t ROW_Y_RESET = 48'h0000_4000_0000;
    localparam row_t ROW_Z_RESET = 48'h4000_0000_0000;

    localparam prod_t ROUND_HALF = prod_t'(1) <<< (COEF_FRAC - 1);

    localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

endpackage

// File: design/affine_point_transform.sv
// ============================================================================
// affine_point_transform: 3x3 matrix plus translation on Q16.16 points
// Four-stage pipeline: multiply, round, sum, saturate.
// ============================================================================
// Path: an input transfer passes the multiply, round, sum and saturate stage
//   registers before its result shows on the output channel.
// Throughput: one point per cycle while the output is not stalled; each stage
//   holds on downstream stall and refills in the cycle it drains.
// Reset: all stage valid bits clear, the matrix returns to identity and the
//   translations to zero. cfg_ready is always high.
module affine_point_transform
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  apt_pkg::cfg_idx_t cfg_index,
    input  apt_pkg::row_t     cfg_data,

    input  logic              in_valid,
    output logic              in_ready,
    input  apt_pkg::coord_t   x_in,
    input  apt_pkg::coord_t   y_in,
    input  apt_pkg::coord_t   z_in,

    output logic              out_valid,
    input  logic              out_ready,
    output apt_pkg::coord_t   x_out,
    output apt_pkg::coord_t   y_out,
    output apt_pkg::coord_t   z_out,
    output logic              clipped
);
    import apt_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    row_t   row_reg   [NUM_AXES];
    coord_t shift_reg [NUM_AXES];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0]   <= ROW_X_RESET;
            row_reg[1]   <= ROW_Y_RESET;
            row_reg[2]   <= ROW_Z_RESET;
            shift_reg[0] <= '0;
            shift_reg[1] <= '0;
            shift_reg[2] <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            // Drop writes to indexes past the register list.
            case (cfg_index)
                REG_ROW_X:   row_reg[0]   <= cfg_data;
                REG_ROW_Y:   row_reg[1]   <= cfg_data;
                REG_ROW_Z:   row_reg[2]   <= cfg_data;
                REG_SHIFT_X: shift_reg[0] <= cfg_data[COORD_W-1:0];
                REG_SHIFT_Y: shift_reg[1] <= cfg_data[COORD_W-1:0];
                REG_SHIFT_Z: shift_reg[2] <= cfg_data[COORD_W-1:0];
                default:     ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage takes new data when it is empty or
    // when its own contents move on in the same cycle.
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: nine coefficient-by-coordinate products, exact Q18.30
    // ------------------------------------------------------------------
    coord_t pnt [NUM_AXES];
    prod_t  prod_next [NUM_AXES][NUM_AXES];
    prod_t  prod_reg  [NUM_AXES][NUM_AXES];

    assign pnt[0] = x_in;
    assign pnt[1] = y_in;
    assign pnt[2] = z_in;

    always_comb
    begin
        for (int r = 0; r < NUM_AXES; r++)
        begin
            for (int k = 0; k < NUM_AXES; k++)
            begin
                prod_next[r][k] = prod_t'(coef_t'(row_reg[r][k*COEF_W +: COEF_W]))
                                * prod_t'(pnt[k]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: round each product to Q18.16, ties toward plus infinity
    // ------------------------------------------------------------------
    rnd_t rnd_next [NUM_AXES][NUM_AXES];
    rnd_t rnd_reg  [NUM_AXES][NUM_AXES];
    prod_t biased  [NUM_AXES][NUM_AXES];

    always_comb
    begin
        for (int r = 0; r < NUM_AXES; r++)
        begin
            for (int k = 0; k < NUM_AXES; k++)
            begin
                biased[r][k]   = prod_reg[r][k] + ROUND_HALF;
                rnd_next[r][k] = biased[r][k][PROD_W-1:COEF_FRAC];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: exact sum of rounded products and translation
    // ------------------------------------------------------------------
    sum_t sum_next [NUM_AXES];
    sum_t sum_reg  [NUM_AXES];

    always_comb
    begin
        for (int r = 0; r < NUM_AXES; r++)
        begin
            sum_next[r] = sum_t'(shift_reg[r]) + sum_t'(rnd_reg[r][0])
                        + sum_t'(rnd_reg[r][1]) + sum_t'(rnd_reg[r][2]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: saturate to 32 bits, flag any clipped axis
    // ------------------------------------------------------------------
    coord_t sat_next [NUM_AXES];
    logic   [NUM_AXES-1:0] hit;
    coord_t res_reg  [NUM_AXES];
    logic   clip_reg;

    always_comb
    begin
        for (int r = 0; r < NUM_AXES; r++)
        begin
            if (sum_reg[r] > sum_t'(COORD_MAX))
            begin
                sat_next[r] = COORD_MAX;
                hit[r]      = 1'b1;
            end
            else if (sum_reg[r] < sum_t'(COORD_MIN))
            begin
                sat_next[r] = COORD_MIN;
                hit[r]      = 1'b1;
            end
            else
            begin
                sat_next[r] = sum_reg[r][COORD_W-1:0];
                hit[r]      = 1'b0;
            end
        end
    end

    // Payload registers: load only when the stage advances with valid data.
    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid) prod_reg <= prod_next;
        if (rdy2 && v1_reg)   rnd_reg  <= rnd_next;
        if (rdy3 && v2_reg)   sum_reg  <= sum_next;
        if (rdy4 && v3_reg)
        begin
            res_reg  <= sat_next;
            clip_reg <= |hit;
        end
    end

    assign out_valid = v4_reg;
    assign x_out     = res_reg[0];
    assign y_out     = res_reg[1];
    assign z_out     = res_reg[2];
    assign clipped   = clip_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_clip_means_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clipped |->
            (x_out == COORD_MAX) || (x_out == COORD_MIN) ||
            (y_out == COORD_MAX) || (y_out == COORD_MIN) ||
            (z_out == COORD_MAX) || (z_out == COORD_MIN))
        else $error("clipped set with no coordinate at a limit");

    a_transfer_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> v1_reg)
        else $error("input transfer lost before stage 1");

    a_empty_s1_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !v1_reg |-> in_ready)
        else $error("input stalled with empty first stage");

    a_s3_holds: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && !rdy3 |=> v3_reg && $stable(sum_reg[0]) && $stable(sum_reg[2]))
        else $error("sum stage changed while stalled");

    a_drain_moves: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && !v4_reg |=> v4_reg)
        else $error("sum stage failed to advance into empty output stage");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb: self-checking bench for affine_point_transform
// Streams Q16.16 points through the block under several matrix settings and
// flow-control mixes, predicts every transformed point in a scoreboard and
// compares each output transfer field by field against the oldest prediction.
// ============================================================================
module tb;

    import apt_pkg::*;

    // Run limit: ~850 points under heavy stall, plus the long hold-off and
    // config traffic, taken many times over.
    localparam int unsigned RUN_LIMIT  = 200000;
    localparam int          HOLD_CYCLES = 300;  // receiver hold-off length
    localparam int          DRAIN_PAD   = 8;    // pipeline is 4 deep
    localparam int          BURST_LEN   = 100;  // points per matrix setting
    localparam int          MAX_REPORTS = 10;

    // Indexes past the last register; writes there must be dropped
    localparam cfg_idx_t UNMAPPED_IDX_0 = REG_SHIFT_Z + 3'd1;
    localparam cfg_idx_t UNMAPPED_IDX_1 = REG_SHIFT_Z + 3'd2;

    localparam longint ROUND_BIAS = longint'(1) <<< (COEF_FRAC - 1);

    typedef struct {
        coord_t x;
        coord_t y;
        coord_t z;
        logic   clip;
    } xformed_point_t;

    // ------------------------------------------------------------------------
    // Scoreboard: holds its own copy of the matrix, predicts each accepted
    // point and matches output transfers in order.
    // ------------------------------------------------------------------------
    class xform_scoreboard;
        row_t           rows[NUM_AXES];
        coord_t         shifts[NUM_AXES];
        xformed_point_t pending_points[$];
        int             mismatches;

        function new();
            rows[0]    = ROW_X_RESET;
            rows[1]    = ROW_Y_RESET;
            rows[2]    = ROW_Z_RESET;
            shifts[0]  = '0;
            shifts[1]  = '0;
            shifts[2]  = '0;
            mismatches = 0;
        endfunction

        function void apply_reg_write(cfg_idx_t idx, row_t data);
            case (idx)
                REG_ROW_X:   rows[0] = data;
                REG_ROW_Y:   rows[1] = data;
                REG_ROW_Z:   rows[2] = data;
                REG_SHIFT_X: shifts[0] = data[COORD_W-1:0];
                REG_SHIFT_Y: shifts[1] = data[COORD_W-1:0];
                REG_SHIFT_Z: shifts[2] = data[COORD_W-1:0];
                default:     ;
            endcase
        endfunction

        // Round each product to nearest (ties up), sum exactly, saturate
        function xformed_point_t transform_point(coord_t px, coord_t py, coord_t pz);
            coord_t         pt[NUM_AXES];
            coord_t         outs[NUM_AXES];
            xformed_point_t res;
            longint         acc;
            longint         prod;
            coef_t          c;
            pt[0]    = px;
            pt[1]    = py;
            pt[2]    = pz;
            res.clip = 1'b0;
            for (int a = 0; a < NUM_AXES; a++) begin
                acc = longint'(shifts[a]);
                for (int k = 0; k < NUM_AXES; k++) begin
                    c    = rows[a][k*COEF_W +: COEF_W];
                    prod = longint'(c) * longint'(pt[k]);
                    acc += (prod + ROUND_BIAS) >>> COEF_FRAC;
                end
                if (acc > longint'(COORD_MAX)) begin
                    acc      = longint'(COORD_MAX);
                    res.clip = 1'b1;
                end
                else if (acc < longint'(COORD_MIN)) begin
                    acc      = longint'(COORD_MIN);
                    res.clip = 1'b1;
                end
                outs[a] = coord_t'(acc);
            end
            res.x = outs[0];
            res.y = outs[1];
            res.z = outs[2];
            return res;
        endfunction

        function void note_point(coord_t px, coord_t py, coord_t pz);
            pending_points.push_back(transform_point(px, py, pz));
        endfunction

        function void check_result(coord_t rx, coord_t ry, coord_t rz, logic rclip);
            xformed_point_t want;
            if (pending_points.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected output transfer: x=%0d y=%0d z=%0d clipped=%0b",
                             rx, ry, rz, rclip);
                return;
            end
            want = pending_points.pop_front();
            if (rx !== want.x || ry !== want.y || rz !== want.z || rclip !== want.clip)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"mismatch: exp x=%0d y=%0d z=%0d clipped=%0b, ",
                              "got x=%0d y=%0d z=%0d clipped=%0b"},
                             want.x, want.y, want.z, want.clip, rx, ry, rz, rclip);
            end
        endfunction

        function int pending_count();
            return pending_points.size();
        endfunction

        function void flush_leftover();
            if (pending_points.size() != 0) begin
                $display("%0d predicted points never came out", pending_points.size());
                mismatches += pending_points.size();
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block I/O
    // ------------------------------------------------------------------------
    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     cfg_valid = 1'b0;
    logic     cfg_ready;
    cfg_idx_t cfg_index = '0;
    row_t     cfg_data  = '0;
    logic     in_valid  = 1'b0;
    logic     in_ready;
    coord_t   x_in      = '0;
    coord_t   y_in      = '0;
    coord_t   z_in      = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    coord_t   x_out;
    coord_t   y_out;
    coord_t   z_out;
    logic     clipped;

    xform_scoreboard sb = new();

    int          sender_idle_pct    = 0;  // chance per cycle the sender idles
    int          receiver_stall_pct = 0;  // chance per cycle the receiver stalls
    int          hold_requests      = 0;  // bumped by the main flow only
    int          hold_served        = 0;  // bumped by the receiver only
    int          hold_left          = 0;
    int unsigned cycle_count        = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    affine_point_transform u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .x_in      (x_in),
        .y_in      (y_in),
        .z_in      (z_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .x_out     (x_out),
        .y_out     (y_out),
        .z_out     (z_out),
        .clipped   (clipped)
    );

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off on request. The hold-off
    // is counted here so the sender keeps pushing and the pipe backs up.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_served != hold_requests) begin
            hold_served <= hold_served + 1;
            hold_left   <= HOLD_CYCLES;
            out_ready   <= 1'b0;
        end
        else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else begin
            out_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: sample both channels on the edge. Note the input transfer
    // before checking the output so a purely combinational block would still line up.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && in_ready)
                sb.note_point(x_in, y_in, z_in);
            if (out_valid && out_ready)
                sb.check_result(x_out, y_out, z_out, clipped);
        end
    end

    // Watchdog: abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Random field values, weighted toward small magnitudes and extremes
    // ------------------------------------------------------------------------
    function automatic coord_t rand_coord();
        logic [19:0] narrow;
        narrow = 20'($urandom);
        case ($urandom_range(3))
            0: return coord_t'($signed(narrow));
            1:
            begin
                case ($urandom_range(4))
                    0:       return COORD_MAX;
                    1:       return COORD_MIN;
                    2:       return '0;
                    3:       return '1;
                    default: return coord_t'(1);
                endcase
            end
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic coef_t rand_coef();
        logic [9:0] tiny;
        tiny = 10'($urandom);
        case ($urandom_range(3))
            0: return coef_t'($signed(tiny));
            1:
            begin
                case ($urandom_range(4))
                    0:       return 16'sh7FFF;
                    1:       return 16'sh8000;
                    2:       return '0;
                    3:       return 16'sh4000;   // +1.0
                    default: return 16'shC000;   // -1.0
                endcase
            end
            default: return coef_t'($urandom);
        endcase
    endfunction

    function automatic row_t rand_row();
        return {rand_coef(), rand_coef(), rand_coef()};
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // One config transfer; the caller drops cfg_valid after its last write
    task automatic cfg_write(input cfg_idx_t idx, input row_t data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.apply_reg_write(idx, data);
    endtask

    // Idle at random, then offer one point and hold it until the transfer
    task automatic send_point(input coord_t px, input coord_t py, input coord_t pz);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        x_in     <= px;
        y_in     <= py;
        z_in     <= pz;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_random_burst(input int count);
        repeat (count) send_point(rand_coord(), rand_coord(), rand_coord());
        in_valid <= 1'b0;
    endtask

    // Every point yields a result, so an empty queue plus the pipe depth
    // means the block is idle. Wait for a clock edge first so the monitor has
    // noted the last input transfer.
    task automatic wait_drained();
        @(posedge clk);
        while (sb.pending_count() != 0) @(posedge clk);
        repeat (DRAIN_PAD) @(posedge clk);
    endtask

    // Fresh matrix; shifts carry junk in the upper data bits, which must be
    // ignored, and now and then a write lands on an unmapped index.
    task automatic load_random_matrix();
        cfg_write(REG_ROW_X, rand_row());
        cfg_write(REG_ROW_Y, rand_row());
        cfg_write(REG_ROW_Z, rand_row());
        cfg_write(REG_SHIFT_X, {16'($urandom), rand_coord()});
        cfg_write(REG_SHIFT_Y, {16'($urandom), rand_coord()});
        cfg_write(REG_SHIFT_Z, {16'($urandom), rand_coord()});
        if ($urandom_range(3) == 0)
            cfg_write($urandom_range(1) ? UNMAPPED_IDX_0 : UNMAPPED_IDX_1,
                      row_t'({$urandom, $urandom}));
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main flow
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Identity matrix out of reset: extremes pass through untouched
        send_point('0, '0, '0);
        send_point(COORD_MAX, COORD_MIN, '1);
        send_point(COORD_MIN, COORD_MAX, coord_t'(1));
        send_point(32'h0001_2345, 32'hFFFE_DCBB, 32'h7FFF_0000);
        in_valid <= 1'b0;
        wait_drained();

        // Extreme coefficients and shifts: -2.0, ~+2.0 and one LSB rows.
        // Shift Y and Z writes carry junk above bit 31.
        cfg_write(REG_ROW_X, {3{16'h8000}});
        cfg_write(REG_ROW_Y, {3{16'h7FFF}});
        cfg_write(REG_ROW_Z, {3{16'h0001}});
        cfg_write(REG_SHIFT_X, {16'h0000, COORD_MAX});
        cfg_write(REG_SHIFT_Y, {16'hFFFF, COORD_MIN});
        cfg_write(REG_SHIFT_Z, 48'hABCD_0000_0001);
        cfg_valid <= 1'b0;

        // Saturate low and high; the Z row hits rounding ties both ways
        send_point(COORD_MAX, COORD_MAX, COORD_MAX);
        send_point(COORD_MIN, COORD_MIN, COORD_MIN);
        send_point(32'h0000_2000, 32'h0000_6000, 32'hFFFF_E000);
        send_point(32'hFFFF_A000, 32'hFFFF_E000, 32'h0000_2000);
        send_point('0, '0, '0);
        send_point(coord_t'(1), coord_t'(1), coord_t'(1));
        send_point('1, '1, '1);
        in_valid <= 1'b0;
        wait_drained();

        // Writes to unmapped indexes must leave the matrix alone
        cfg_write(UNMAPPED_IDX_0, '1);
        cfg_write(UNMAPPED_IDX_1, '1);
        cfg_valid <= 1'b0;
        send_point('0, '0, '0);
        send_point(32'h0000_2000, 32'h0000_6000, 32'hFFFF_E000);
        in_valid <= 1'b0;

        // Random traffic: no idling, sender gaps, receiver stalls, both
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = 56;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 56;
                end
                default:
                begin
                    sender_idle_pct    = 31;
                    receiver_stall_pct = 31;
                end
            endcase
            repeat (2) begin
                wait_drained();
                load_random_matrix();
                send_random_burst(BURST_LEN);
            end
        end

        // Back-pressure: hold the receiver off while the sender streams
        // flat out, so the pipe fills and in_ready drops.
        wait_drained();
        load_random_matrix();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_requests      = hold_requests + 1;
        send_random_burst(50);

        wait_drained();
        sb.flush_leftover();
        if (sb.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
